@@ hdl/matrix_keypad_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// matrix keypad scanner assertion macros
// shared forms for the concurrent checks of the keypad scanner
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_pkg
// shared types and constants of the matrix keypad scanner
// ----------------------------------------------------------------------------
package mks_pkg;

  // register widths and reset values
  localparam int SETTLE_W  = 16;
  localparam int LOCKOUT_W = 24;
  localparam int CNT_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 16'd100;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 24'd80000;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd1;

  // scan sequencer phases
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_ALL_HIGH = 6'b000010,
    PH_COL_LOW  = 6'b000100,
    PH_COL_HIGH = 6'b001000,
    PH_ALL_LOW  = 6'b010000,
    PH_LOCKOUT  = 6'b100000
  } phase_t;

  // timing registers handed to the sequencer
  typedef struct packed {
    logic [SETTLE_W-1:0]  settle;
    logic [LOCKOUT_W-1:0] lockout;
  } cfg_t;

endpackage

@@ hdl/matrix_keypad_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// column scan sequencer for a matrix keypad, one time tick per input item
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per time tick (wake request and sampled row levels).
//   out_*  : result items; each tick gives one item, or one per low row on
//            the tick that samples a column (out_last marks the final one).
//   cfg_*  : register writes (settle_ticks, lockout_ticks), taken every cycle
//            while cfg_valid is high; unknown indexes are dropped.
// Latency: the first result of a tick is shown the cycle after the tick is
//   accepted.
// Throughput: one tick per cycle while out_ready is high; a sampling tick
//   with k low rows holds the result register until all k keys are out, as
//   the single result register hands the keys out one per cycle while out_ready is high.
// Reset: sequencer goes idle with all columns low and no pending request;
//   registers return to settle 100 and lockout 80000 ticks.
// Stall: while out_ready is low the result register holds and in_ready
//   drops once it is full, so no tick is lost; the sequencer advances only
//   on accepted ticks.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
  parameter int  ROWS  = 4,
  parameter int  COLS  = 4,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_wake_request,
  input  logic [ROWS-1:0]                 in_row_levels,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COLS-1:0]                 out_column_drive,
  output logic                            out_key_valid,
  output logic [ROW_W-1:0]                out_key_row,
  output logic [COL_W-1:0]                out_key_column,
  output logic                            out_scanning,
  output logic                            out_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mks_pkg::LOCKOUT_W-1:0]   cfg_data
);

  mks_pkg::cfg_t     cfg_r;
  logic              in_acc, out_acc;
  logic [COLS-1:0]   res_drive;
  logic [ROWS-1:0]   res_keys;
  logic [COL_W-1:0]  res_col;
  logic              res_scan;

  logic              grp_vld_r;
  logic [COLS-1:0]   grp_drive_r;
  logic [ROWS-1:0]   grp_keys_r;
  logic [COL_W-1:0]  grp_col_r;
  logic              grp_scan_r;

  logic              any_key;
  logic              one_left;
  logic [ROW_W-1:0]  low_row;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle  <= mks_pkg::SETTLE_RESET;
      cfg_r.lockout <= mks_pkg::LOCKOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mks_pkg::CFG_SETTLE:  cfg_r.settle  <= cfg_data[mks_pkg::SETTLE_W-1:0];
        mks_pkg::CFG_LOCKOUT: cfg_r.lockout <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign in_ready = !grp_vld_r || (out_ready && one_left);

  // scan sequencer
  mks_seq #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .wake      (in_wake_request),
    .rows      (in_row_levels),
    .cfg       (cfg_r),
    .res_drive (res_drive),
    .res_keys  (res_keys),
    .res_col   (res_col),
    .res_scan  (res_scan)
  );

  // lowest pressed row still to report
  always_comb begin
    low_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (grp_keys_r[i]) begin
        low_row = ROW_W'(i);
      end
    end
  end

  assign any_key  = |grp_keys_r;
  assign one_left = ((grp_keys_r & (grp_keys_r - ROWS'(1))) == '0);

  // result register, emptied one key per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
    end else if (in_acc) begin
      grp_vld_r <= 1'b1;
    end else if (out_acc && one_left) begin
      grp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      grp_drive_r <= res_drive;
      grp_keys_r  <= res_keys;
      grp_col_r   <= res_col;
      grp_scan_r  <= res_scan;
    end else if (out_acc) begin
      grp_keys_r  <= grp_keys_r & (grp_keys_r - ROWS'(1));
    end
  end

  // result fields
  assign out_valid        = grp_vld_r;
  assign out_column_drive = grp_drive_r;
  assign out_key_valid    = any_key;
  assign out_key_row      = any_key ? low_row : '0;
  assign out_key_column   = any_key ? grp_col_r : '0;
  assign out_scanning     = grp_scan_r;
  assign out_last         = one_left;

endmodule

@@ hdl/mks_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_seq
// scan sequencer: advances phase, column and wait counter once per tick
// ----------------------------------------------------------------------------
module mks_seq #(
  parameter int  ROWS  = 4,
  parameter int  COLS  = 4,
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              wake,
  input  logic [ROWS-1:0]   rows,
  input  mks_pkg::cfg_t     cfg,
  output logic [COLS-1:0]   res_drive,
  output logic [ROWS-1:0]   res_keys,
  output logic [COL_W-1:0]  res_col,
  output logic              res_scan
);

  localparam logic [COLS-1:0]  ALL_COLS = {COLS{1'b1}};
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

  mks_pkg::phase_t               phase_r, phase_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [mks_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [COLS-1:0]               drive_r, drive_nxt;
  logic                          pend_r, pend_nxt;
  logic [ROWS-1:0]               keys_nxt;
  logic                          done;
  logic [mks_pkg::CNT_W-1:0]     settle_ext;

  assign settle_ext = mks_pkg::CNT_W'(cfg.settle);
  assign done       = (cnt_r <= mks_pkg::CNT_W'(1));

  // next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    cnt_nxt   = done ? '0 : (cnt_r - mks_pkg::CNT_W'(1));
    drive_nxt = drive_r;
    pend_nxt  = pend_r;
    keys_nxt  = '0;
    case (phase_r)
      mks_pkg::PH_ALL_HIGH: begin
        if (done) begin
          drive_nxt = ALL_COLS & ~(COLS'(1) << col_r);
          cnt_nxt   = settle_ext;
          phase_nxt = mks_pkg::PH_COL_LOW;
        end
      end
      mks_pkg::PH_COL_LOW: begin
        if (done) begin
          keys_nxt  = ~rows;
          drive_nxt = ALL_COLS;
          cnt_nxt   = settle_ext;
          phase_nxt = mks_pkg::PH_COL_HIGH;
        end
      end
      mks_pkg::PH_COL_HIGH: begin
        if (done) begin
          cnt_nxt = settle_ext;
          if (col_r >= LAST_COL) begin
            drive_nxt = '0;
            phase_nxt = mks_pkg::PH_ALL_LOW;
          end else begin
            col_nxt   = col_r + COL_W'(1);
            drive_nxt = ALL_COLS & ~(COLS'(1) << (col_r + COL_W'(1)));
            phase_nxt = mks_pkg::PH_COL_LOW;
          end
        end
      end
      mks_pkg::PH_ALL_LOW: begin
        if (done) begin
          cnt_nxt   = cfg.lockout;
          phase_nxt = mks_pkg::PH_LOCKOUT;
          // zero lockout ends on this same tick
          if (cfg.lockout == '0) begin
            if (pend_r) begin
              col_nxt   = '0;
              pend_nxt  = 1'b0;
              drive_nxt = ALL_COLS;
              cnt_nxt   = settle_ext;
              phase_nxt = mks_pkg::PH_ALL_HIGH;
            end else begin
              cnt_nxt   = '0;
              drive_nxt = '0;
              phase_nxt = mks_pkg::PH_IDLE;
            end
          end
        end
      end
      mks_pkg::PH_LOCKOUT: begin
        if (wake) begin
          pend_nxt = 1'b1;
        end
        if (done) begin
          if (pend_r || wake) begin
            col_nxt   = '0;
            pend_nxt  = 1'b0;
            drive_nxt = ALL_COLS;
            cnt_nxt   = settle_ext;
            phase_nxt = mks_pkg::PH_ALL_HIGH;
          end else begin
            cnt_nxt   = '0;
            drive_nxt = '0;
            phase_nxt = mks_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        // idle, and any stray code falls back to idle
        cnt_nxt   = cnt_r;
        phase_nxt = mks_pkg::PH_IDLE;
        drive_nxt = '0;
        if (wake) begin
          col_nxt   = '0;
          pend_nxt  = 1'b0;
          drive_nxt = ALL_COLS;
          cnt_nxt   = settle_ext;
          phase_nxt = mks_pkg::PH_ALL_HIGH;
        end
      end
    endcase
  end

  // sequencer state, advanced on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mks_pkg::PH_IDLE;
      col_r   <= '0;
      cnt_r   <= '0;
      drive_r <= '0;
      pend_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      drive_r <= drive_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // result of this tick
  assign res_drive = drive_nxt;
  assign res_keys  = keys_nxt;
  assign res_col   = col_nxt;
  assign res_scan  = (phase_nxt != mks_pkg::PH_IDLE);

endmodule

@@ hdl/mks_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_chk
// port-level checks of the matrix keypad scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_macros.svh"

module mks_chk #(
  parameter int  ROWS  = 4,
  parameter int  COLS  = 4,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [COLS-1:0]   out_column_drive,
  input  logic              out_key_valid,
  input  logic [ROW_W-1:0]  out_key_row,
  input  logic [COL_W-1:0]  out_key_column,
  input  logic              out_scanning,
  input  logic              out_last
);

  // the keys of one tick come out back to back
  `MKS_ASSERT_NEXT(a_group_continues, out_valid && out_ready && !out_last, out_valid && out_key_valid, "key group broken before its last item")

  // no new tick is taken while keys of the current one remain
  `MKS_ASSERT_NOW(a_no_tick_mid_group, in_valid && out_valid && !out_last, !in_ready, "tick taken while keys remain")

  // idle means all columns low and no key
  `MKS_ASSERT_NOW(a_idle_low, out_valid && !out_scanning, out_column_drive == '0 && !out_key_valid, "idle item with columns driven or a key")

  // a key is reported only while scanning, with all columns driven high again
  `MKS_ASSERT_NOW(a_key_drive, out_valid && out_key_valid, out_scanning && out_column_drive == {COLS{1'b1}}, "key item outside a scan or with wrong drive")

  // a stalled item holds its payload
  `MKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key_row) && $stable(out_key_column) && $stable(out_column_drive), "stalled item changed")

endmodule

bind matrix_keypad_scanner mks_chk #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_mks_chk (.*);

@@ dv/matrix_keypad_scanner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_tb
// drives time ticks into the keypad scanner, mirrors its scan sequencer in a
// local model and checks every result item field by field, under random
// sender gaps, receiver stalls and two long receiver hold-offs
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 100;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_TICKS = 49;

  // indexes that map to no register
  localparam logic [mks_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mks_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic       wake;
    logic [3:0] rows;
  } tick_t;

  typedef struct packed {
    logic [3:0] drive;
    logic       key_valid;
    logic [1:0] key_row;
    logic [1:0] key_col;
    logic       scanning;
    logic       last;
  } key_report_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_wake_request = 1'b0;
  logic [3:0]                    in_row_levels = 4'hF;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [3:0]                    out_column_drive;
  logic                          out_key_valid;
  logic [1:0]                    out_key_row;
  logic [1:0]                    out_key_column;
  logic                          out_scanning;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mks_pkg::CFG_IDX_W-1:0] cfg_index = mks_pkg::CFG_SETTLE;
  logic [mks_pkg::LOCKOUT_W-1:0] cfg_data = '0;

  // stimulus and expectation stores
  tick_t       ticks_to_send[$];
  key_report_t pending_reports[$];
  tick_t       next_tick;
  key_report_t got_report;
  logic        quiet = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          results_seen = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // local copy of registers and sequencer state
  logic [mks_pkg::SETTLE_W-1:0]  settle_reg = mks_pkg::SETTLE_RESET;
  logic [mks_pkg::LOCKOUT_W-1:0] lockout_reg = mks_pkg::LOCKOUT_RESET;
  mks_pkg::phase_t               seq_phase = mks_pkg::PH_IDLE;
  logic [1:0]                    col_idx = 2'd0;
  logic [mks_pkg::CNT_W-1:0]     wait_cnt = '0;
  logic [3:0]                    drive = 4'h0;
  logic                          wake_latched = 1'b0;

  matrix_keypad_scanner uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_wake_request (in_wake_request),
    .in_row_levels   (in_row_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column_drive(out_column_drive),
    .out_key_valid   (out_key_valid),
    .out_key_row     (out_key_row),
    .out_key_column  (out_key_column),
    .out_scanning    (out_scanning),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // count down the current wait, true once it runs out
  function automatic logic wait_elapsed();
    if (wait_cnt <= 1) begin
      wait_cnt = '0;
      return 1'b1;
    end
    wait_cnt = wait_cnt - 1'b1;
    return 1'b0;
  endfunction

  function automatic void drive_columns(input logic [3:0] levels,
                                        input mks_pkg::phase_t nxt);
    drive = levels;
    wait_cnt = mks_pkg::CNT_W'(settle_reg);
    seq_phase = nxt;
  endfunction

  function automatic void begin_scan();
    col_idx = 2'd0;
    wake_latched = 1'b0;
    drive_columns(4'hF, mks_pkg::PH_ALL_HIGH);
  endfunction

  function automatic void leave_lockout();
    if (wake_latched) begin
      begin_scan();
    end else begin
      seq_phase = mks_pkg::PH_IDLE;
      wait_cnt = '0;
      drive = 4'h0;
    end
  endfunction

  // advance the sequencer by one tick and queue the key reports it gives
  function automatic void scan_tick(input logic wake, input logic [3:0] rows);
    logic [1:0]  low_rows [4];
    int          n_low;
    int          n_out;
    key_report_t rpt;
    n_low = 0;
    case (seq_phase)
      mks_pkg::PH_ALL_HIGH: begin
        if (wait_elapsed()) drive_columns(~(4'b0001 << col_idx), mks_pkg::PH_COL_LOW);
      end
      mks_pkg::PH_COL_LOW: begin
        if (wait_elapsed()) begin
          for (int r = 0; r < 4; r++) begin
            if (!rows[r]) begin
              low_rows[n_low] = 2'(r);
              n_low++;
            end
          end
          drive_columns(4'hF, mks_pkg::PH_COL_HIGH);
        end
      end
      mks_pkg::PH_COL_HIGH: begin
        if (wait_elapsed()) begin
          if (col_idx == 2'd3) begin
            drive_columns(4'h0, mks_pkg::PH_ALL_LOW);
          end else begin
            col_idx = col_idx + 2'd1;
            drive_columns(~(4'b0001 << col_idx), mks_pkg::PH_COL_LOW);
          end
        end
      end
      mks_pkg::PH_ALL_LOW: begin
        if (wait_elapsed()) begin
          wait_cnt = lockout_reg;
          seq_phase = mks_pkg::PH_LOCKOUT;
          if (lockout_reg == 0) leave_lockout();
        end
      end
      mks_pkg::PH_LOCKOUT: begin
        if (wake) wake_latched = 1'b1;
        if (wait_elapsed()) leave_lockout();
      end
      default: begin
        seq_phase = mks_pkg::PH_IDLE;
        drive = 4'h0;
        if (wake) begin_scan();
      end
    endcase
    n_out = (n_low > 0) ? n_low : 1;
    for (int k = 0; k < n_out; k++) begin
      rpt.drive     = drive;
      rpt.key_valid = (n_low > 0);
      rpt.key_row   = (n_low > 0) ? low_rows[k] : 2'd0;
      rpt.key_col   = (n_low > 0) ? col_idx : 2'd0;
      rpt.scanning  = (seq_phase != mks_pkg::PH_IDLE);
      rpt.last      = (k == n_out - 1);
      pending_reports.push_back(rpt);
    end
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  // tick sender, with random gaps after accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0 && !quiet) begin
        in_valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (ticks_to_send.size() > 0) begin
        next_tick = ticks_to_send.pop_front();
        in_valid <= 1'b1;
        in_wake_request <= next_tick.wake;
        in_row_levels <= next_tick.rows;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen == 30 || results_seen == 250) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0 && !quiet) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // watch all three channels: register writes, results, accepted ticks
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mks_pkg::CFG_SETTLE:  settle_reg = cfg_data[mks_pkg::SETTLE_W-1:0];
          mks_pkg::CFG_LOCKOUT: lockout_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result with none expected, actual drive %0h key %0b row %0d col %0d",
                   $time, out_column_drive, out_key_valid, out_key_row, out_key_column);
          err_cnt++;
        end else begin
          got_report = pending_reports.pop_front();
          check_field("column_drive", got_report.drive, out_column_drive);
          check_field("key_valid", got_report.key_valid, out_key_valid);
          check_field("key_row", got_report.key_row, out_key_row);
          check_field("key_column", got_report.key_col, out_key_column);
          check_field("scanning", got_report.scanning, out_scanning);
          check_field("last", got_report.last, out_last);
        end
      end
      if (in_valid && in_ready) scan_tick(in_wake_request, in_row_levels);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("matrix_keypad_scanner_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [mks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mks_pkg::LOCKOUT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_tick(input logic wake, input logic [3:0] rows);
    tick_t t;
    t.wake = wake;
    t.rows = rows;
    ticks_to_send.push_back(t);
  endtask

  // wait until every tick is sent and every report has come back
  task automatic wait_drained();
    while (ticks_to_send.size() != 0 || in_valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // an idle tick at reset timing, rows are ignored while idle
    push_tick(1'b0, 4'h0);
    wait_drained();

    // largest timing values, kept idle so no wait is ever loaded
    write_reg(mks_pkg::CFG_SETTLE, 24'hFFFFFF);
    write_reg(mks_pkg::CFG_LOCKOUT, 24'hFFFFFF);
    push_tick(1'b0, 4'h5);
    push_tick(1'b0, 4'hA);
    wait_drained();

    // writes to unused indexes must change nothing
    write_reg(CFG_SPARE_LO, 24'h000002);
    write_reg(CFG_SPARE_HI, 24'h000003);

    // shortest settle, no lockout: full scan with keys in several columns
    write_reg(mks_pkg::CFG_SETTLE, 24'h5A0001);
    write_reg(mks_pkg::CFG_LOCKOUT, 24'h000000);
    push_tick(1'b1, 4'hF);
    push_tick(1'b0, 4'hF);
    push_tick(1'b0, 4'h0);
    push_tick(1'b1, 4'h0);
    push_tick(1'b0, 4'hE);
    push_tick(1'b0, 4'hF);
    push_tick(1'b0, 4'h7);
    push_tick(1'b0, 4'hF);
    push_tick(1'b0, 4'hF);
    push_tick(1'b1, 4'hF);
    push_tick(1'b0, 4'hF);
    wait_drained();

    // zero settle acts as one; a request in the all-low phase is ignored and lockout begins
    write_reg(mks_pkg::CFG_SETTLE, 24'hA50000);
    write_reg(mks_pkg::CFG_LOCKOUT, 24'h000002);
    push_tick(1'b1, 4'hF);
    for (int i = 0; i < 9; i++) push_tick(1'b0, 4'(i * 5));
    push_tick(1'b1, 4'hF);
    push_tick(1'b0, 4'hF);
    wait_drained();

    // random phases at varied timing, last one without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) quiet <= 1'b1;
      write_reg(mks_pkg::CFG_SETTLE,
                {8'($urandom), (p == 2) ? 16'd0 : 16'($urandom_range(1, 6))});
      write_reg(mks_pkg::CFG_LOCKOUT, (p == 1) ? 24'd0 : 24'($urandom_range(0, 40)));
      for (int i = 0; i < PHASE_TICKS; i++)
        push_tick($urandom_range(0, 5) == 0,
                  $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15)));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("matrix_keypad_scanner_tb: clean");
    end else begin
      $display("matrix_keypad_scanner_tb: errors");
    end
    $finish;
  end

endmodule
